FILE: design/rle_xor_delta_frame_decoder_defines.svh
// assertion macros for the rle xor delta frame decoder
`ifndef RLE_XOR_DELTA_FRAME_DECODER_DEFINES_SVH
`define RLE_XOR_DELTA_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define RXD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rxd assertion failed");

// implication checked at every clock edge out of reset
`define RXD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rxd implication failed");

`else

`define RXD_ASSERT(lbl, clk, rst_n, prop)
`define RXD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/rxd_pkg.sv
package rxd_pkg;

  // default sizes
  localparam int unsigned FRAME_BYTES_DEF = 16384;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // bytes carried by one result, one store bank per byte lane
  localparam int unsigned LANES  = 4;
  localparam int unsigned LANE_W = $clog2(LANES);

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned POS_OUT_W = 14;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 15'd16384;

  // stream payload widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 9;
  localparam int unsigned M_TDATA_W =
    ((LANES * BYTE_W + COUNT_W + POS_OUT_W + 7) / 8) * 8;
  localparam int unsigned M_TUSER_W = 2;

  typedef enum logic [7:0] {
    TYPE_KEY   = 8'd0,
    TYPE_DELTA = 8'd1
  } frame_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_DROPPED  = 2'd2
  } status_e;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_FRAME_SIZE = 1'b0
  } reg_idx_e;

  // classified run handed from front to back
  typedef struct packed {
    logic        delta;
    logic [7:0]  value;
    logic [7:0]  take;
    status_e     status;
  } item_t;

endpackage

FILE: design/rxd_queue.sv
module rxd_queue #(
  parameter int unsigned POS_W = 15,
  parameter int unsigned DEPTH = rxd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rxd_pkg::item_t       push_item_i,
  input  logic [POS_W-1:0]     push_pos_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output rxd_pkg::item_t       pop_item_o,
  output logic [POS_W-1:0]     pop_pos_o,
  input  logic                 pop_i
);
  import rxd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             item_q [DEPTH];
  logic [POS_W-1:0]  pos_q  [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = item_q[rptr_q];
  assign pop_pos_o    = pos_q[rptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  // pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      item_q[wptr_q] <= push_item_i;
      pos_q[wptr_q]  <= push_pos_i;
    end
  end

endmodule

FILE: design/rxd_front.sv
module rxd_front #(
  parameter int unsigned FRAME_BYTES = rxd_pkg::FRAME_BYTES_DEF,
  localparam int unsigned POS_W = $clog2(FRAME_BYTES) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [rxd_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [rxd_pkg::S_TUSER_W-1:0] s_tuser_i,
  input  logic [rxd_pkg::CFG_W-1:0]     frame_size_i,
  output logic                          push_o,
  output rxd_pkg::item_t                push_item_o,
  output logic [POS_W-1:0]              push_pos_o,
  input  logic                          push_ready_i
);
  import rxd_pkg::*;

  localparam int unsigned CMP_W = (POS_W > CFG_W) ? POS_W : CFG_W;

  logic [7:0]       frame_type;
  logic             frame_start;
  logic [7:0]       run_count;
  logic [7:0]       run_value;
  logic             accept, bad_type, dropped;
  logic [POS_W-1:0] base, limit, avail;
  logic [CMP_W-1:0] limit_wide;
  logic [7:0]       take;
  logic [POS_W-1:0] wp_q, wp_d;

  // unpack the item
  assign frame_type  = s_tuser_i[7:0];
  assign frame_start = s_tuser_i[8];
  assign run_count   = s_tdata_i[7:0];
  assign run_value   = s_tdata_i[15:8];

  assign s_tready_o = push_ready_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign bad_type   = (frame_type != TYPE_KEY) && (frame_type != TYPE_DELTA);

  // room left in the frame and the part of the run that fits
  always_comb begin
    base       = frame_start ? '0 : wp_q;
    limit_wide = (CMP_W'(frame_size_i) > CMP_W'(FRAME_BYTES)) ?
                 CMP_W'(FRAME_BYTES) : CMP_W'(frame_size_i);
    limit      = POS_W'(limit_wide);
    avail      = (base < limit) ? (limit - base) : '0;
    if (CMP_W'(run_count) < CMP_W'(avail)) begin
      take = run_count;
    end else begin
      take = 8'(avail);
    end
    dropped = (CMP_W'(run_count) > CMP_W'(avail));
  end

  // classified item for the back end
  always_comb begin
    push_item_o.delta  = (frame_type == TYPE_DELTA);
    push_item_o.value  = run_value;
    push_item_o.take   = bad_type ? 8'd0 : take;
    if (bad_type) begin
      push_item_o.status = ST_BAD_TYPE;
    end else if (dropped) begin
      push_item_o.status = ST_DROPPED;
    end else begin
      push_item_o.status = ST_OK;
    end
    push_pos_o = bad_type ? wp_q : base;
  end

  // zero-length runs only move the write position
  assign push_o = accept && (bad_type || (run_count != 8'd0));

  always_comb begin
    wp_d = wp_q;
    if (accept && !bad_type) begin
      wp_d = base + POS_W'(take);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else begin
      wp_q <= wp_d;
    end
  end

endmodule

FILE: design/rxd_back.sv
`include "rle_xor_delta_frame_decoder_defines.svh"

module rxd_back #(
  parameter int unsigned FRAME_BYTES = rxd_pkg::FRAME_BYTES_DEF,
  localparam int unsigned POS_W = $clog2(FRAME_BYTES) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  input  rxd_pkg::item_t                pop_item_i,
  input  logic [POS_W-1:0]              pop_pos_i,
  output logic                          pop_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [rxd_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic [rxd_pkg::M_TUSER_W-1:0] m_tuser_o,
  output logic                          m_tlast_o
);
  import rxd_pkg::*;

  localparam int unsigned BANK_DEPTH = (FRAME_BYTES + LANES - 1) / LANES;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

  // run being cut into chunks
  logic             r_active_q, r_active_d;
  logic [POS_W-1:0] r_pos_q, r_pos_d;
  logic [7:0]       r_rem_q, r_rem_d;
  logic             r_delta_q;
  logic [7:0]       r_value_q;
  status_e          r_status_q;

  // chunk waiting on store read data
  logic               x_valid_q, x_valid_d;
  logic [POS_W-1:0]   x_pos_q;
  logic [COUNT_W-1:0] x_k_q;
  logic               x_last_q;
  status_e            x_status_q;
  logic               x_delta_q;
  logic [7:0]         x_value_q;
  logic [LANES-1:0]   x_en_q;
  logic [LANES-1:0]   x_known_q;
  logic [BANK_AW-1:0] x_baddr_q [LANES];

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    out_bytes_q [LANES];
  logic [COUNT_W-1:0]   out_count_q;
  logic [POS_OUT_W-1:0] out_pos_q;
  status_e              out_status_q;
  logic                 out_last_q;

  // fill mark: store bytes at or above it were never written since reset
  logic [POS_W-1:0] hw_q, hw_d;

  logic               x_go, x_free, issue, load;
  logic [COUNT_W-1:0] r_k;
  logic               r_last_chunk;
  logic [LANE_W-1:0]  offs  [LANES];
  logic [POS_W-1:0]   addr  [LANES];
  logic [LANES-1:0]   ren, known;
  logic [BANK_AW-1:0] baddr [LANES];
  logic [BYTE_W-1:0]  rdata_q [LANES];
  logic [BYTE_W-1:0]  nb    [LANES];
  logic [BYTE_W-1:0]  lane  [LANES];
  logic [POS_W-1:0]   x_end;

  // pipeline flow
  assign x_go   = x_valid_q && (!out_valid_q || m_tready_i);
  assign x_free = !x_valid_q || x_go;
  assign issue  = r_active_q && x_free;
  assign load   = !r_active_q && x_free && pop_valid_i;
  assign pop_o  = load;

  assign r_k = (r_rem_q < 8'(LANES)) ? COUNT_W'(r_rem_q) : COUNT_W'(LANES);
  assign r_last_chunk = (r_rem_q <= 8'(LANES));

  // bank addresses for the chunk being issued
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      offs[b]  = LANE_W'(b) - r_pos_q[LANE_W-1:0];
      addr[b]  = r_pos_q + POS_W'(offs[b]);
      ren[b]   = issue && (COUNT_W'(offs[b]) < r_k);
      known[b] = (addr[b] < hw_q);
      baddr[b] = BANK_AW'(addr[b] >> LANE_W);
    end
  end

  // restored byte per bank
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      nb[b] = x_delta_q ? (x_value_q ^ (x_known_q[b] ? rdata_q[b] : '0)) : x_value_q;
    end
  end

  // bank order to frame order
  always_comb begin
    logic [LANE_W-1:0] sel;
    for (int i = 0; i < LANES; i++) begin
      sel     = x_pos_q[LANE_W-1:0] + LANE_W'(i);
      lane[i] = (COUNT_W'(i) < x_k_q) ? nb[sel] : '0;
    end
  end

  // frame store, one byte bank per lane
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [BYTE_W-1:0] mem_q [BANK_DEPTH];

    always_ff @(posedge clk_i) begin
      if (x_go && x_en_q[b]) begin
        mem_q[x_baddr_q[b]] <= nb[b];
      end
      if (ren[b]) begin
        rdata_q[b] <= mem_q[baddr[b]];
      end
    end
  end

  // next control state
  always_comb begin
    r_active_d  = r_active_q;
    r_pos_d     = r_pos_q;
    r_rem_d     = r_rem_q;
    x_valid_d   = x_valid_q;
    out_valid_d = out_valid_q;
    hw_d        = hw_q;
    x_end       = x_pos_q + POS_W'(x_k_q);

    if (load) begin
      r_active_d = 1'b1;
      r_pos_d    = pop_pos_i;
      r_rem_d    = pop_item_i.take;
    end else if (issue) begin
      r_pos_d = r_pos_q + POS_W'(r_k);
      r_rem_d = r_rem_q - 8'(r_k);
      if (r_last_chunk) begin
        r_active_d = 1'b0;
      end
    end

    if (issue) begin
      x_valid_d = 1'b1;
    end else if (x_go) begin
      x_valid_d = 1'b0;
    end

    if (x_go) begin
      out_valid_d = 1'b1;
      if (x_end > hw_q) begin
        hw_d = x_end;
      end
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_active_q  <= 1'b0;
      r_pos_q     <= '0;
      r_rem_q     <= '0;
      x_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hw_q        <= '0;
    end else begin
      r_active_q  <= r_active_d;
      r_pos_q     <= r_pos_d;
      r_rem_q     <= r_rem_d;
      x_valid_q   <= x_valid_d;
      out_valid_q <= out_valid_d;
      hw_q        <= hw_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      r_delta_q  <= pop_item_i.delta;
      r_value_q  <= pop_item_i.value;
      r_status_q <= pop_item_i.status;
    end
    if (issue) begin
      x_pos_q    <= r_pos_q;
      x_k_q      <= r_k;
      x_last_q   <= r_last_chunk;
      x_status_q <= r_last_chunk ? r_status_q : ST_OK;
      x_delta_q  <= r_delta_q;
      x_value_q  <= r_value_q;
      x_en_q     <= ren;
      x_known_q  <= known;
      for (int b = 0; b < LANES; b++) begin
        x_baddr_q[b] <= baddr[b];
      end
    end
    if (x_go) begin
      for (int i = 0; i < LANES; i++) begin
        out_bytes_q[i] <= lane[i];
      end
      out_count_q  <= x_k_q;
      out_pos_q    <= POS_OUT_W'(x_pos_q);
      out_status_q <= x_status_q;
      out_last_q   <= x_last_q;
    end
  end

  // output packing
  always_comb begin
    m_tdata_o = '0;
    for (int i = 0; i < LANES; i++) begin
      m_tdata_o[i*BYTE_W +: BYTE_W] = out_bytes_q[i];
    end
    m_tdata_o[LANES*BYTE_W +: COUNT_W]           = out_count_q;
    m_tdata_o[LANES*BYTE_W + COUNT_W +: POS_OUT_W] = out_pos_q;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

  // checks
  `RXD_ASSERT(a_fill_in_range, clk_i, rst_ni, hw_q <= POS_W'(FRAME_BYTES))
  `RXD_ASSERT_IMPLY(a_status_on_last, clk_i, rst_ni,
    out_valid_q && (out_status_q != ST_OK), out_last_q)
  `RXD_ASSERT_IMPLY(a_error_empty, clk_i, rst_ni,
    out_valid_q && (out_status_q == ST_BAD_TYPE), out_count_q == '0)
  `RXD_ASSERT_IMPLY(a_empty_is_flagged, clk_i, rst_ni,
    out_valid_q && (out_count_q == '0), out_last_q && (out_status_q != ST_OK))

endmodule

FILE: design/rle_xor_delta_frame_decoder.sv
// rle xor delta frame decoder
//
// s_axis carries one run-length pair per item: tdata holds run_count and
// run_value, tuser holds frame_type and frame_start. m_axis carries results of
// up to four restored bytes with valid_count and position in tdata, status in
// tuser and tlast on the last result of each pair. The apb port holds the
// frame_size register at address 0; the user must write it only while the
// block idles, as the block itself does not enforce this.
// a pair that keeps n bytes gives ceil(n/4) results, one per cycle unless
// m_axis stalls; error and drop-only pairs give one empty result, zero-length
// pairs none. a pair is loaded into the back end only after the last chunk of
// the one before is issued. the rate is set by the four-bank frame store, one
// read and one write byte port per bank, and its registered read ahead of the
// xor. a pair passes the queue, run, chunk and result registers to m_axis.
//
// reset clears the write position and the fill mark of the frame store, so
// unwritten bytes read as zero; no clearing pass is needed. when m_axis stalls
// the result is held, the back end and then the two-entry queue fill, and
// s_axis tready drops.
module rle_xor_delta_frame_decoder #(
  parameter int unsigned FRAME_BYTES = rxd_pkg::FRAME_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = rxd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // run_count [7:0], run_value [15:8]
  input  logic [rxd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // frame_type [7:0], frame_start [8]
  input  logic [rxd_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // byte_zero [7:0], byte_one [15:8], byte_two [23:16], byte_three [31:24],
  // valid_count [34:32], position [48:35], zero [55:49]
  output logic [rxd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [rxd_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rxd_pkg::APB_AW-1:0]    paddr,
  input  logic [rxd_pkg::APB_DW-1:0]    pwdata,
  output logic [rxd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import rxd_pkg::*;

  localparam int unsigned POS_W = $clog2(FRAME_BYTES) + 1;

  logic [CFG_W-1:0] frame_size_q;
  logic             cfg_write, reg_hit;

  logic             push, push_ready, pop_valid, pop;
  item_t            push_item, pop_item;
  logic [POS_W-1:0] push_pos, pop_pos;

  // register file
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[2] == REG_FRAME_SIZE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_hit ? APB_DW'(frame_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= FRAME_SIZE_RESET;
    end else if (cfg_write && reg_hit) begin
      frame_size_q <= pwdata[CFG_W-1:0];
    end
  end

  // front end: classify and clip each pair
  rxd_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .frame_size_i (frame_size_q),
    .push_o       (push),
    .push_item_o  (push_item),
    .push_pos_o   (push_pos),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  rxd_queue #(
    .POS_W (POS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_pos_i   (push_pos),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_pos_o    (pop_pos),
    .pop_i        (pop)
  );

  // back end: expand, restore against the store, emit
  rxd_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_pos_i   (pop_pos),
    .pop_o       (pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

FILE: tb/sv/rle_xor_delta_frame_decoder_test.sv
module rle_xor_delta_frame_decoder_test;
  import rxd_pkg::*;

  localparam int unsigned STORE_BYTES   = FRAME_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  // covers a full run in the back end, plus the pipeline ahead of it
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned REPORT_QUIET  = 100;

  // one result item as it leaves m_axis
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  nvalid;
    logic [13:0] pos;
    status_e     status;
    logic        last;
  } result_t;

  // one row of directed stimulus: a register write or a pair
  typedef struct packed {
    logic             set_size;
    logic [CFG_W-1:0] size;
    logic [7:0]       ftype;
    logic             start;
    logic [7:0]       count;
    logic [7:0]       value;
    logic             typed;
    result_t          want;
  } stim_row_t;

  typedef enum logic [1:0] {
    MIX_FRAMES,
    MIX_PRESSURE,
    MIX_LONG
  } mix_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic [S_TUSER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  // shadow of the frame store, write position and frame size
  logic [7:0]            shadow_frame [STORE_BYTES];
  int unsigned           shadow_pos;
  int unsigned           shadow_size;

  result_t               pending_results [$];
  stim_row_t             directed_rows [$];
  int unsigned           mismatches;
  int unsigned           cycles;
  int unsigned           idle_pct;
  int unsigned           stall_pct;
  bit                    hold_pending;

  rle_xor_delta_frame_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    // quiet after the first hundred, but keep counting
    if (mismatches <= REPORT_QUIET)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
  endtask

  // append one expected result item
  function automatic void queue_result(input result_t r);
    pending_results = {pending_results, r};
  endfunction

  // append one directed row
  function automatic void add_row(input stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // expand one pair against the shadow store, queue its results, return how many
  function automatic int unsigned expand_run(input logic [7:0] ftype, input logic start,
                                             input logic [7:0] count,
                                             input logic [7:0] value);
    int unsigned limit, avail, take, dropped, k, n, a;
    logic [7:0]  b;
    result_t     r;
    n = 0;
    // bad type: one error item, pair otherwise ignored
    if (ftype != TYPE_KEY && ftype != TYPE_DELTA) begin
      r = '0;
      r.pos = 14'(shadow_pos);
      r.status = ST_BAD_TYPE;
      r.last = 1'b1;
      queue_result(r);
      return 1;
    end
    if (start)
      shadow_pos = 0;
    if (count == 0)
      return 0;
    limit = (shadow_size > STORE_BYTES) ? STORE_BYTES : shadow_size;
    avail = (shadow_pos < limit) ? limit - shadow_pos : 0;
    take = (count < avail) ? count : avail;
    dropped = count - take;
    // up to four bytes per item, restored and written back
    while (take > 0) begin
      k = (take < LANES) ? take : LANES;
      r = '0;
      r.pos = 14'(shadow_pos);
      r.nvalid = 3'(k);
      for (int unsigned i = 0; i < k; i++) begin
        a = shadow_pos + i;
        b = (ftype == TYPE_DELTA) ? (value ^ shadow_frame[a]) : value;
        shadow_frame[a] = b;
        r.bytes[8*i +: 8] = b;
      end
      shadow_pos += k;
      take -= k;
      if (take == 0) begin
        r.status = (dropped > 0) ? ST_DROPPED : ST_OK;
        r.last = 1'b1;
      end else begin
        r.status = ST_OK;
      end
      queue_result(r);
      n++;
    end
    // nothing fitted: a lone drop item
    if (dropped > 0 && n == 0) begin
      r = '0;
      r.pos = 14'(shadow_pos);
      r.status = ST_DROPPED;
      r.last = 1'b1;
      queue_result(r);
      n = 1;
    end
    return n;
  endfunction

  function automatic stim_row_t pair_row(input logic [7:0] ftype, input logic start,
                                         input logic [7:0] count, input logic [7:0] value);
    stim_row_t row;
    row = '0;
    row.ftype = ftype;
    row.start = start;
    row.count = count;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input stim_row_t row, input logic [31:0] bytes,
                                          input logic [2:0] nvalid, input int unsigned pos,
                                          input status_e status);
    row.typed = 1'b1;
    row.want.bytes = bytes;
    row.want.nvalid = nvalid;
    row.want.pos = 14'(pos);
    row.want.status = status;
    row.want.last = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t size_row(input logic [CFG_W-1:0] size);
    stim_row_t row;
    row = '0;
    row.set_size = 1'b1;
    row.size = size;
    return row;
  endfunction

  // offer one pair, hold it until taken, then queue what it should give
  task automatic send_pair(input stim_row_t row);
    int unsigned n;
    s_axis_tdata <= {row.value, row.count};
    s_axis_tuser <= {row.start, row.ftype};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n = expand_run(row.ftype, row.start, row.count, row.value);
    if (row.typed) begin
      repeat (n) void'(pending_results.pop_back());
      queue_result(row.want);
    end
  endtask

  // random idle cycles between items
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // idle the block before touching the register
  task automatic quiesce();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // setup and access cycle for the write, then read back
  task automatic write_frame_size(input logic [CFG_W-1:0] size);
    logic [APB_AW-1:0] addr;
    addr = {REG_FRAME_SIZE, 2'b00};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= APB_DW'(size);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(size))
      report_mismatch("frame_size readback", prdata, size);
    psel <= 1'b0;
    penable <= 1'b0;
    shadow_size = size;
  endtask

  // one random phase at one register setting and one idling profile
  task automatic run_phase(input mix_e mix, input int unsigned send_idle,
                           input int unsigned recv_stall, input logic [CFG_W-1:0] size,
                           input int unsigned items);
    stim_row_t   row;
    int unsigned frame_left;
    logic [7:0]  kind;
    quiesce();
    write_frame_size(size);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    if (mix == MIX_PRESSURE)
      hold_pending = 1'b1;
    frame_left = 0;
    kind = TYPE_KEY;
    for (int unsigned i = 0; i < items; i++) begin
      row = '0;
      row.value = 8'($urandom);
      if (mix == MIX_LONG) begin
        // one frame of full runs that overruns the whole store
        row.ftype = $urandom_range(1) ? TYPE_DELTA : TYPE_KEY;
        row.start = (i == 0);
        row.count = 8'd255;
      end else begin
        // well-formed frames: a start item, then runs of the same type
        if (frame_left == 0) begin
          frame_left = $urandom_range(10, 1);
          kind = ($urandom_range(99) < 40) ? TYPE_KEY : TYPE_DELTA;
          row.start = 1'b1;
        end else begin
          row.start = ($urandom_range(99) < 4);
        end
        frame_left--;
        row.ftype = kind;
        // noise: a bad frame type now and then
        if ($urandom_range(99) < 8)
          row.ftype = 8'($urandom_range(255, 2));
        case ($urandom_range(9))
          0:             row.count = 8'd0;
          1, 2, 3, 4, 5: row.count = 8'($urandom_range(12, 1));
          6, 7:          row.count = 8'($urandom_range(64, 13));
          default:       row.count = 8'($urandom_range(255, 65));
        endcase
      end
      send_pair(row);
      // sender waits for everything outstanding mid-way through
      if (mix == MIX_PRESSURE && i == items / 2)
        drain_results();
      sender_gap();
    end
  endtask

  // receiver: random stalls, and a long hold-off when asked
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_left = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.bytes)
          report_mismatch("bytes", m_axis_tdata[31:0], want.bytes);
        if (m_axis_tdata[34:32] !== want.nvalid)
          report_mismatch("valid_count", m_axis_tdata[34:32], want.nvalid);
        if (m_axis_tdata[48:35] !== want.pos)
          report_mismatch("position", m_axis_tdata[48:35], want.pos);
        if (m_axis_tdata[M_TDATA_W-1:49] !== '0)
          report_mismatch("tdata padding", m_axis_tdata[M_TDATA_W-1:49], '0);
        if (m_axis_tuser !== want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // stimulus
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    mismatches = 0;
    hold_pending = 1'b0;
    idle_pct = 20;
    stall_pct = 20;
    foreach (shadow_frame[a])
      shadow_frame[a] = '0;
    shadow_pos = 0;
    shadow_size = FRAME_SIZE_RESET;

    // delta before any keyframe xors with the cleared store
    add_row(typed_row(pair_row(TYPE_DELTA, 1'b1, 8'd4, 8'h5a),
                      32'h5a5a5a5a, 3'd4, 0, ST_OK));
    // full-length runs of each type
    add_row(pair_row(TYPE_KEY, 1'b1, 8'd255, 8'hff));
    add_row(pair_row(TYPE_DELTA, 1'b1, 8'd255, 8'h00));
    add_row(pair_row(TYPE_DELTA, 1'b0, 8'd255, 8'ha5));
    // zero count gives nothing, but the start mark still rewinds
    add_row(pair_row(TYPE_KEY, 1'b1, 8'd0, 8'h12));
    // bad frame types, start mark and count ignored
    add_row(typed_row(pair_row(8'h02, 1'b1, 8'd10, 8'h34),
                      '0, 3'd0, 0, ST_BAD_TYPE));
    add_row(typed_row(pair_row(8'hff, 1'b0, 8'd255, 8'hff),
                      '0, 3'd0, 0, ST_BAD_TYPE));
    add_row(typed_row(pair_row(8'h80, 1'b1, 8'd0, 8'h00),
                      '0, 3'd0, 0, ST_BAD_TYPE));
    // shorter keyframe over a longer one, then a delta across both
    add_row(pair_row(TYPE_KEY, 1'b0, 8'd3, 8'h11));
    add_row(pair_row(TYPE_DELTA, 1'b0, 8'd5, 8'h80));
    add_row(pair_row(TYPE_KEY, 1'b1, 8'd2, 8'h00));
    add_row(pair_row(TYPE_DELTA, 1'b1, 8'd9, 8'h0f));
    // frame size lowered under the write position
    add_row(size_row(15'd4));
    add_row(typed_row(pair_row(TYPE_KEY, 1'b0, 8'd3, 8'h66),
                      '0, 3'd0, 9, ST_DROPPED));
    add_row(typed_row(pair_row(TYPE_KEY, 1'b1, 8'd6, 8'hc3),
                      32'hc3c3c3c3, 3'd4, 0, ST_DROPPED));
    add_row(typed_row(pair_row(TYPE_KEY, 1'b0, 8'd1, 8'h01),
                      '0, 3'd0, 4, ST_DROPPED));
    // one-byte frames
    add_row(size_row(15'd1));
    add_row(typed_row(pair_row(TYPE_KEY, 1'b1, 8'd1, 8'h7e),
                      32'h0000007e, 3'd1, 0, ST_OK));
    add_row(typed_row(pair_row(TYPE_DELTA, 1'b1, 8'd255, 8'h81),
                      32'h000000ff, 3'd1, 0, ST_DROPPED));
    add_row(pair_row(TYPE_DELTA, 1'b0, 8'd0, 8'h00));
    add_row(size_row(15'd16384));
    add_row(pair_row(TYPE_DELTA, 1'b1, 8'd7, 8'h3c));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_size) begin
        quiesce();
        write_frame_size(directed_rows[r].size);
      end else begin
        send_pair(directed_rows[r]);
        sender_gap();
      end
    end

    // random part
    run_phase(MIX_FRAMES, 0, 0, 15'd16384, 70);
    run_phase(MIX_FRAMES, 48, 0, 15'd97, 70);
    run_phase(MIX_FRAMES, 0, 48, 15'd256, 70);
    run_phase(MIX_FRAMES, 20, 20, 15'd1, 50);
    run_phase(MIX_PRESSURE, 0, 0, 15'd16384, 60);
    run_phase(MIX_LONG, 20, 20, 15'd16384, 70);

    // wind down
    stall_pct = 0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/rxd_pkg.sv
design/rxd_queue.sv
design/rxd_front.sv
design/rxd_back.sv
design/rle_xor_delta_frame_decoder.sv
tb/sv/rle_xor_delta_frame_decoder_test.sv
